@@ rtl/bstne_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and note tables for the button scan to note events block.
// Used by every module of the block; depends on nothing.
package bstne_pkg;

   localparam int BUTTON_COUNT_DEF = 8;
   localparam int POT_MAX_DEF      = 1023;
   localparam int NOTE_SPAN        = 116;
   localparam int VELOCITY_SPAN    = 126;
   localparam int NOTE_W           = 7;
   localparam int INDEX_W          = 3;
   localparam int POT_W            = 10;
   localparam int MODE_W           = 2;
   localparam logic [NOTE_W-1:0] NOTE_MAX   = 7'd127;
   localparam logic [NOTE_W-1:0] BASE_RESET = 7'd21;

   typedef struct packed {
      logic              fire;
      logic              is_on;
      logic [NOTE_W-1:0] note;
   } lane_result_type;

   localparam logic [3:0] SCALE_OFFSETS [4][8] = '{
      '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd8, 4'd11, 4'd13},
      '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd13},
      '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd13},
      '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd12}
   };

   localparam logic [NOTE_W-1:0] DRUM_NOTES [8] = '{
      7'd36, 7'd38, 7'd48, 7'd41, 7'd45, 7'd42, 7'd46, 7'd55
   };

endpackage

@@ rtl/bstne_pot_scale.sv @@
`timescale 1ns / 1ps
// Three-stage pipelined pot scaler: (POT_MAX - pot) * SPAN / POT_MAX, truncated.
// The divide is a reciprocal multiply with one correction step. Uses bstne_pkg.
module bstne_pot_scale #(
   parameter int POT_MAX = bstne_pkg::POT_MAX_DEF,
   parameter int SPAN    = bstne_pkg::NOTE_SPAN
) (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [bstne_pkg::POT_W-1:0]     pot,
   output logic [$clog2(SPAN+1)-1:0]       scaled
);
   import bstne_pkg::*;

   localparam int D_W   = $clog2(POT_MAX + 1);
   localparam int IN_W  = (D_W > POT_W) ? D_W : POT_W;
   localparam int X_W   = $clog2(POT_MAX * SPAN + 1);
   localparam int RECIP = (1 << X_W) / POT_MAX;
   localparam int R_W   = $clog2(RECIP + 1);
   localparam int Q_W   = $clog2(SPAN + 1);

   logic [IN_W-1:0]    pot_ext;
   logic [D_W-1:0]     pot_sat;
   logic [X_W-1:0]     x_in, x_ff, xd_ff;
   logic [X_W+R_W-1:0] prod;
   logic [Q_W-1:0]     q0_in, q0_ff, q_in, q_ff;
   logic [X_W-1:0]     rem;

   always_comb begin
      pot_ext = IN_W'(pot);
      if (pot_ext > IN_W'(POT_MAX)) begin
         pot_sat = D_W'(POT_MAX);
      end else begin
         pot_sat = D_W'(pot_ext);
      end
      x_in  = X_W'(D_W'(POT_MAX) - pot_sat) * X_W'(SPAN);
      prod  = (X_W+R_W)'(x_ff) * (X_W+R_W)'(RECIP);
      q0_in = Q_W'(prod >> X_W);
      rem   = xd_ff - X_W'(q0_ff) * X_W'(POT_MAX);
      if (rem >= X_W'(POT_MAX)) begin
         q_in = q0_ff + 1'b1;
      end else begin
         q_in = q0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff  <= x_in;
         xd_ff <= x_ff;
         q0_ff <= q0_in;
         q_ff  <= q_in;
      end
   end

   assign scaled = q_ff;

endmodule

@@ rtl/bstne_lane.sv @@
`timescale 1ns / 1ps
// One button lane: note lookup, press and release detection, held-bit update.
// Uses the note tables and lane result type of bstne_pkg.
module bstne_lane #(
   parameter int LANE = 0
) (
   input  logic                             button_n,
   input  logic                             held,
   input  logic                             hold_high,
   input  logic                             drum,
   input  logic [bstne_pkg::NOTE_W-1:0]     base_note,
   input  logic [bstne_pkg::MODE_W-1:0]     scale_mode,
   output bstne_pkg::lane_result_type       result,
   output logic                             held_next
);
   import bstne_pkg::*;

   logic [NOTE_W:0] sum;
   logic            pressed;
   logic            note_on;

   always_comb begin
      sum     = {1'b0, base_note} + (NOTE_W+1)'(SCALE_OFFSETS[scale_mode][LANE]);
      pressed = !button_n;
      note_on = pressed && !held && hold_high;
      if (drum) begin
         result.note = DRUM_NOTES[LANE];
      end else if (sum > (NOTE_W+1)'(NOTE_MAX)) begin
         result.note = NOTE_MAX;
      end else begin
         result.note = sum[NOTE_W-1:0];
      end
      result.fire  = note_on || !pressed;
      result.is_on = note_on;
      held_next    = pressed && (held || note_on);
   end

endmodule

@@ rtl/bstne_merge.sv @@
`timescale 1ns / 1ps
// Event buffer that merges the lane results of one scan and sends them out in
// button order through a registered result stage. Uses bstne_pkg.
module bstne_merge #(
   parameter int LANES = bstne_pkg::BUTTON_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  bstne_pkg::lane_result_type        lanes [LANES],
   input  logic [bstne_pkg::NOTE_W-1:0]      velocity,
   output logic                              load_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_is_note_on,
   output logic [bstne_pkg::INDEX_W-1:0]     rsp_button_index,
   output logic [bstne_pkg::NOTE_W-1:0]      rsp_note_number,
   output logic [bstne_pkg::NOTE_W-1:0]      rsp_note_velocity,
   output logic                              rsp_last
);
   import bstne_pkg::*;

   logic [LANES-1:0]   pend_ff, pend_in, low, remaining, fire_mask;
   logic [LANES-1:0]   on_ff;
   logic [NOTE_W-1:0]  note_ff [LANES];
   logic [NOTE_W-1:0]  vel_ff;
   logic [INDEX_W-1:0] pick;
   logic               out_free, move;
   logic               valid_ff, valid_in;
   logic               on_out_ff, last_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [NOTE_W-1:0]  note_out_ff, vel_out_ff;

   always_comb begin
      low       = pend_ff & (~pend_ff + 1'b1);
      remaining = pend_ff & ~low;
      pick      = '0;
      for (int j = 0; j < LANES; j++) begin
         fire_mask[j] = lanes[j].fire;
         if (low[j]) begin
            pick = pick | INDEX_W'(j);
         end
      end
      out_free   = !valid_ff || rsp_ready;
      move       = out_free && (pend_ff != '0);
      load_ready = (pend_ff == '0) || (out_free && (remaining == '0));
      if (load) begin
         pend_in = fire_mask;
      end else if (move) begin
         pend_in = remaining;
      end else begin
         pend_in = pend_ff;
      end
      if (move) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int j = 0; j < LANES; j++) begin
            on_ff[j]   <= lanes[j].is_on;
            note_ff[j] <= lanes[j].note;
         end
         vel_ff <= velocity;
      end
      if (move) begin
         on_out_ff   <= on_ff[pick];
         index_ff    <= pick;
         note_out_ff <= note_ff[pick];
         vel_out_ff  <= on_ff[pick] ? vel_ff : '0;
         last_ff     <= (remaining == '0);
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_is_note_on    = on_out_ff;
   assign rsp_button_index  = index_ff;
   assign rsp_note_number   = note_out_ff;
   assign rsp_note_velocity = vel_out_ff;
   assign rsp_last          = last_ff;

endmodule

@@ rtl/button_scan_to_note_events.sv @@
`timescale 1ns / 1ps
// Button scan to note events: turns scans of eight buttons and two pots into
// note-on and note-off events. Depends on bstne_pkg, bstne_pot_scale,
// bstne_lane and bstne_merge.
//
// A scan is one transaction on the req_ channel. Each scan passes three
// pipeline stages that scale the two pots, then all button lanes evaluate it
// combinationally in parallel, update the held state and the base note, and hand
// their events to the event buffer. The buffer sends the events in button order,
// one per cycle while rsp_ready is high, through a registered rsp_ stage; rsp_last
// marks the final event of a scan, and a scan with no events sends nothing.
// A scan's events hold the event buffer, which sends them one at a time on its
// single result register and takes the next scan only as the last one moves out.
// When the receiver stalls, the result holds; req_ready falls and the pipeline
// stops once the buffer is still busy with a scan at the last pipeline stage.
// The csr_ channel writes the scale mode and is always ready.
// Synchronous reset clears the pipeline, the events in flight, the held
// buttons and the scale mode, and sets the base note to 21.
module button_scan_to_note_events #(
   parameter int BUTTON_COUNT = bstne_pkg::BUTTON_COUNT_DEF,
   parameter int POT_MAX      = bstne_pkg::POT_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_buttons_n,
   input  logic                              req_scale_switch_n,
   input  logic                              req_hold_switch_n,
   input  logic [bstne_pkg::POT_W-1:0]       req_note_pot,
   input  logic [bstne_pkg::POT_W-1:0]       req_velocity_pot,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_is_note_on,
   output logic [bstne_pkg::INDEX_W-1:0]     rsp_button_index,
   output logic [bstne_pkg::NOTE_W-1:0]      rsp_note_number,
   output logic [bstne_pkg::NOTE_W-1:0]      rsp_note_velocity,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bstne_pkg::MODE_W-1:0]      csr_scale_mode
);
   import bstne_pkg::*;

   localparam int NQ_W = $clog2(NOTE_SPAN + 1);
   localparam int VQ_W = $clog2(VELOCITY_SPAN + 1);

   logic [2:0]              stage_valid_ff, stage_valid_in;
   logic [BUTTON_COUNT-1:0] buttons_ff [3];
   logic [2:0]              drum_ff, hold_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [NOTE_W-1:0]       base_ff, base_in;
   logic [BUTTON_COUNT-1:0] held_ff, held_in;
   logic [NQ_W-1:0]         note_q;
   logic [VQ_W-1:0]         vel_q;
   logic [NOTE_W-1:0]       base_eff, velocity;
   logic                    advance, commit, load_ready;
   lane_result_type         lanes [BUTTON_COUNT];

   assign advance   = !stage_valid_ff[2] || load_ready;
   assign commit    = stage_valid_ff[2] && load_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   bstne_pot_scale #(.POT_MAX(POT_MAX), .SPAN(NOTE_SPAN)) u_note_scale (
      .clock  (clock),
      .enable (advance),
      .pot    (req_note_pot),
      .scaled (note_q)
   );

   bstne_pot_scale #(.POT_MAX(POT_MAX), .SPAN(VELOCITY_SPAN)) u_vel_scale (
      .clock  (clock),
      .enable (advance),
      .pot    (req_velocity_pot),
      .scaled (vel_q)
   );

   assign base_eff = hold_ff[2] ? base_ff : NOTE_W'(note_q);
   assign velocity = NOTE_W'(vel_q) + 1'b1;

   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      bstne_lane #(.LANE(i)) u_lane (
         .button_n   (buttons_ff[2][i]),
         .held       (held_ff[i]),
         .hold_high  (hold_ff[2]),
         .drum       (drum_ff[2]),
         .base_note  (base_eff),
         .scale_mode (mode_ff),
         .result     (lanes[i]),
         .held_next  (held_in[i])
      );
   end

   assign base_in = base_eff;

   always_comb begin
      if (advance) begin
         stage_valid_in = {stage_valid_ff[1:0], req_valid};
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         mode_ff        <= '0;
         base_ff        <= BASE_RESET;
         held_ff        <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_valid) begin
            mode_ff <= csr_scale_mode;
         end
         if (commit) begin
            base_ff <= base_in;
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         buttons_ff[0] <= req_buttons_n[BUTTON_COUNT-1:0];
         buttons_ff[1] <= buttons_ff[0];
         buttons_ff[2] <= buttons_ff[1];
         drum_ff       <= {drum_ff[1:0], req_scale_switch_n};
         hold_ff       <= {hold_ff[1:0], req_hold_switch_n};
      end
   end

   bstne_merge #(.LANES(BUTTON_COUNT)) u_merge (
      .clock             (clock),
      .reset             (reset),
      .load              (commit),
      .lanes             (lanes),
      .velocity          (velocity),
      .load_ready        (load_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_note_on    (rsp_is_note_on),
      .rsp_button_index  (rsp_button_index),
      .rsp_note_number   (rsp_note_number),
      .rsp_note_velocity (rsp_note_velocity),
      .rsp_last          (rsp_last)
   );

endmodule

@@ rtl/bstne_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for button_scan_to_note_events, bound to the top level.
// Uses bstne_pkg for field widths.
module bstne_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_is_note_on,
   input logic [bstne_pkg::INDEX_W-1:0] rsp_button_index,
   input logic [bstne_pkg::NOTE_W-1:0]  rsp_note_number,
   input logic [bstne_pkg::NOTE_W-1:0]  rsp_note_velocity,
   input logic                          rsp_last
);
   import bstne_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_note_on)
         && $stable(rsp_button_index) && $stable(rsp_note_number)
         && $stable(rsp_note_velocity) && $stable(rsp_last))
      else $error("Stalled result transaction changed.");

   a_off_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_note_on |-> rsp_note_velocity == '0)
      else $error("Note-off transaction with nonzero velocity.");

   a_on_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_note_on |-> rsp_note_velocity != '0)
      else $error("Note-on transaction with zero velocity.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

endmodule

bind button_scan_to_note_events bstne_checker u_bstne_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_is_note_on    (rsp_is_note_on),
   .rsp_button_index  (rsp_button_index),
   .rsp_note_number   (rsp_note_number),
   .rsp_note_velocity (rsp_note_velocity),
   .rsp_last          (rsp_last)
);
